### rtl/core/ssem_pkg.sv
// ----------------------------------------------------------------------------
// SSEM step core package
// Shared types and constants for the small-scale experimental machine core.
// ----------------------------------------------------------------------------
package ssem_pkg;

  // Store geometry and instruction layout.
  localparam int unsigned StoreLines = 32;
  localparam int unsigned LineW      = 5;
  localparam int unsigned WordW      = 32;
  localparam int unsigned OpcodeLsb  = 13;
  localparam int unsigned OpcodeW    = 3;

  // Function requested by one input transaction.
  typedef enum logic [1:0] {
    FuncWrite = 2'd0,
    FuncRead  = 2'd1,
    FuncStep  = 2'd2,
    FuncClear = 2'd3
  } func_e;

  // Instruction opcodes. Subtract is decoded from two codes.
  typedef enum logic [OpcodeW-1:0] {
    OpJmp  = 3'd0,
    OpJrp  = 3'd1,
    OpLdn  = 3'd2,
    OpSto  = 3'd3,
    OpSub  = 3'd4,
    OpSubB = 3'd5,
    OpCmp  = 3'd6,
    OpStp  = 3'd7
  } opcode_e;

  // One input transaction as held in the input register.
  typedef struct packed {
    func_e              func;
    logic [LineW-1:0]   line_address;
    logic [WordW-1:0]   word_data;
  } item_t;

  // One result transaction as held in the result register.
  typedef struct packed {
    logic [WordW-1:0]   read_word;
    logic [WordW-1:0]   acc_value;
    logic [LineW-1:0]   counter_value;
    logic               halted;
    logic               executed;
  } result_t;

endpackage

### rtl/core/ssem_machine.sv
// ----------------------------------------------------------------------------
// SSEM machine state and execute logic
// Holds the store, accumulator, counter and flags, and applies one item per
// fire strobe in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module ssem_machine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ssem_pkg::item_t  item_i,
  output ssem_pkg::result_t result_o
);

  logic [ssem_pkg::WordW-1:0] store_q [ssem_pkg::StoreLines];
  logic [ssem_pkg::WordW-1:0] store_d [ssem_pkg::StoreLines];
  logic [ssem_pkg::WordW-1:0] acc_q, acc_d;
  logic [ssem_pkg::LineW-1:0] pc_q, pc_d;
  logic                       skip_q, skip_d;
  logic                       stop_q, stop_d;

  logic [ssem_pkg::LineW-1:0] pc_skip;
  logic [ssem_pkg::LineW-1:0] pc_fetch;
  logic [ssem_pkg::WordW-1:0] instr;
  logic [ssem_pkg::LineW-1:0] operand;
  ssem_pkg::opcode_e          opcode;
  logic [ssem_pkg::WordW-1:0] value;
  logic [ssem_pkg::WordW-1:0] read_word;
  logic                       executed;

  // Fetch path: skip advance, increment, instruction and operand lookup.
  always_comb begin
    pc_skip  = pc_q + ssem_pkg::LineW'(skip_q);
    pc_fetch = pc_skip + ssem_pkg::LineW'(1);
    instr    = store_q[pc_fetch];
    operand  = instr[ssem_pkg::LineW-1:0];
    opcode   = ssem_pkg::opcode_e'(instr[ssem_pkg::OpcodeLsb +: ssem_pkg::OpcodeW]);
    value    = store_q[operand];
  end

  // Next state for the item in the input register.
  always_comb begin
    store_d   = store_q;
    acc_d     = acc_q;
    pc_d      = pc_q;
    skip_d    = skip_q;
    stop_d    = stop_q;
    read_word = '0;
    executed  = 1'b0;
    case (item_i.func)
      ssem_pkg::FuncWrite: begin
        store_d[item_i.line_address] = item_i.word_data;
      end
      ssem_pkg::FuncRead: begin
        read_word = store_q[item_i.line_address];
      end
      ssem_pkg::FuncStep: begin
        // A halted machine ignores steps.
        if (!stop_q) begin
          executed = 1'b1;
          skip_d   = 1'b0;
          pc_d     = pc_fetch;
          case (opcode)
            ssem_pkg::OpJmp:  pc_d = value[ssem_pkg::LineW-1:0];
            ssem_pkg::OpJrp:  pc_d = pc_fetch + value[ssem_pkg::LineW-1:0];
            ssem_pkg::OpLdn:  acc_d = '0 - value;
            ssem_pkg::OpSto:  store_d[operand] = acc_q;
            ssem_pkg::OpSub:  acc_d = acc_q - value;
            ssem_pkg::OpSubB: acc_d = acc_q - value;
            ssem_pkg::OpCmp: begin
              if (acc_q[ssem_pkg::WordW-1]) begin
                skip_d = 1'b1;
              end
            end
            ssem_pkg::OpStp:  stop_d = 1'b1;
            default: ;
          endcase
        end
      end
      ssem_pkg::FuncClear: begin
        for (int i = 0; i < ssem_pkg::StoreLines; i++) begin
          store_d[i] = '0;
        end
        acc_d  = '0;
        pc_d   = '0;
        skip_d = 1'b0;
        stop_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Result reports the state after this item.
  always_comb begin
    result_o.read_word     = read_word;
    result_o.acc_value     = acc_d;
    result_o.counter_value = pc_d;
    result_o.halted        = stop_d;
    result_o.executed      = executed;
  end

  // Machine registers, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ssem_pkg::StoreLines; i++) begin
        store_q[i] <= '0;
      end
      acc_q  <= '0;
      pc_q   <= '0;
      skip_q <= 1'b0;
      stop_q <= 1'b0;
    end else if (fire_i) begin
      store_q <= store_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      skip_q  <= skip_d;
      stop_q  <= stop_d;
    end
  end

endmodule

### rtl/core/ssem_processor_step_core.sv
// ----------------------------------------------------------------------------
// SSEM processor step core
// Top level: input register, machine and result register with stall control.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction (func_i, line_address_i, word_data_i) writes a store
// line, reads a store line, executes one instruction or clears the machine.
// Every input transaction yields exactly one result transaction carrying the
// read word, the accumulator, the counter and the halted and executed flags.
// A transaction moves on a channel at a rising edge with valid high and stall
// low. An accepted item sits in the input register until the result register
// is free or being taken, and is then processed into the result register,
// from which the result shows on the outputs and can be taken.
// One item per cycle is sustained while the receiver does not stall; the path
// from input register to result register (counter increment, two 32-way
// store reads and one 32-bit subtract) sets the cycle time.
// While the receiver stalls, the result holds and one more item may wait in
// the input register; beyond that in_stall_o is raised.
// Reset empties both registers and sets the store, accumulator, counter and
// flags to zero; the block takes items as soon as reset is released.
// ----------------------------------------------------------------------------
module ssem_processor_step_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [4:0]         line_address_i,
  input  logic [31:0]        word_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        read_word_o,
  output logic signed [31:0] acc_value_o,
  output logic [4:0]         counter_value_o,
  output logic               halted_o,
  output logic               executed_o
);

  ssem_pkg::item_t   item_q;
  logic              item_valid_q;
  ssem_pkg::result_t result_d, result_q;
  logic              out_valid_q;
  logic              advance;
  logic              accept;

  // The held item moves on when the result register is free or being taken.
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func         <= ssem_pkg::func_e'(func_i);
      item_q.line_address <= line_address_i;
      item_q.word_data    <= word_data_i;
    end
  end

  // Machine state and execute logic.
  ssem_machine u_machine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .result_o (result_d)
  );

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_word_o     = result_q.read_word;
  assign acc_value_o     = $signed(result_q.acc_value);
  assign counter_value_o = result_q.counter_value;
  assign halted_o        = result_q.halted;
  assign executed_o      = result_q.executed;

endmodule

### rtl/core/ssem_core_checker.sv
// ----------------------------------------------------------------------------
// SSEM step core checker
// Port-level assertions for the step core, attached by a bind statement.
// ----------------------------------------------------------------------------
module ssem_core_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         func_i,
  input logic [4:0]         line_address_i,
  input logic [31:0]        word_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [31:0]        read_word_o,
  input logic signed [31:0] acc_value_o,
  input logic [4:0]         counter_value_o,
  input logic               halted_o,
  input logic               executed_o
);

  // A stalled result transaction stays and holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_word_o) &&
      $stable(acc_value_o) && $stable(counter_value_o) && $stable(halted_o) &&
      $stable(executed_o))
    else $error("stalled result transaction changed");

  // A result transaction leaves only when it was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result transaction dropped while stalled");

  // The core only stalls its input when a result is waiting on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // An executed instruction never reports a read word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && executed_o |-> read_word_o == 32'd0)
    else $error("executed step carries a read word");

  // A stalled input transaction stays and holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(func_i) &&
      $stable(line_address_i) && $stable(word_data_i))
    else $error("stalled input transaction changed");

endmodule

bind ssem_processor_step_core ssem_core_checker u_ssem_core_checker (.*);

### tb/ssem_processor_step_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSEM processor step core testbench
// Drives write, read, step and clear transactions through the valid/stall
// input channel with random gaps. A clocked monitor takes results under
// random stall and compares every field against a machine model kept here.
// ----------------------------------------------------------------------------
module ssem_processor_step_core_test;

  localparam int unsigned ItemTarget = 1450;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;

  // One pending input transaction with the idle cycles that precede it.
  typedef struct {
    ssem_pkg::func_e func;
    logic [4:0]      addr;
    logic [31:0]     data;
    int unsigned     gap;
  } pending_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        func_q = '0;
  logic [4:0]        addr_q = '0;
  logic [31:0]       data_q = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       read_word;
  logic signed [31:0] acc_value;
  logic [4:0]        counter_value;
  logic              halted;
  logic              executed;

  pending_t          pending_items[$];
  ssem_pkg::result_t expected_results[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  bit                gap_calm = 1'b0;
  bit                stall_calm = 1'b0;
  int unsigned       stall_left = 0;

  // Machine state mirrored by the predictor.
  logic [31:0] model_store[ssem_pkg::StoreLines];
  logic [31:0] model_acc;
  logic [4:0]  model_pc;
  logic        model_skip;
  logic        model_stop;

  ssem_processor_step_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func_q),
    .line_address_i (addr_q),
    .word_data_i    (data_q),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .read_word_o    (read_word),
    .acc_value_o    (acc_value),
    .counter_value_o(counter_value),
    .halted_o       (halted),
    .executed_o     (executed)
  );

  always #4 clk_i = ~clk_i;

  // Zero the mirrored machine, as reset and the clear function do.
  function automatic void machine_clear();
    foreach (model_store[i]) model_store[i] = '0;
    model_acc  = '0;
    model_pc   = '0;
    model_skip = 1'b0;
    model_stop = 1'b0;
  endfunction

  // Apply one accepted transaction to the mirrored machine and form its result.
  function automatic ssem_pkg::result_t machine_apply(ssem_pkg::func_e f,
                                                      logic [4:0] a,
                                                      logic [31:0] d);
    ssem_pkg::result_t r;
    logic [31:0]       ins;
    logic [31:0]       val;
    logic [4:0]        opnd;
    ssem_pkg::opcode_e op;
    r = '0;
    case (f)
      ssem_pkg::FuncWrite: model_store[a] = d;
      ssem_pkg::FuncRead:  r.read_word = model_store[a];
      ssem_pkg::FuncStep: begin
        if (!model_stop) begin
          if (model_skip) begin
            model_pc   = model_pc + 5'd1;
            model_skip = 1'b0;
          end
          model_pc = model_pc + 5'd1;
          ins  = model_store[model_pc];
          opnd = ins[ssem_pkg::LineW-1:0];
          op   = ssem_pkg::opcode_e'(ins[ssem_pkg::OpcodeLsb +: ssem_pkg::OpcodeW]);
          val  = model_store[opnd];
          case (op)
            ssem_pkg::OpJmp: model_pc = val[ssem_pkg::LineW-1:0];
            ssem_pkg::OpJrp: model_pc = model_pc + val[ssem_pkg::LineW-1:0];
            ssem_pkg::OpLdn: model_acc = 32'd0 - val;
            ssem_pkg::OpSto: model_store[opnd] = model_acc;
            ssem_pkg::OpSub, ssem_pkg::OpSubB: model_acc = model_acc - val;
            ssem_pkg::OpCmp: begin
              if (model_acc[31]) model_skip = 1'b1;
            end
            default: model_stop = 1'b1;
          endcase
          r.executed = 1'b1;
        end
      end
      default: machine_clear();
    endcase
    r.acc_value     = model_acc;
    r.counter_value = model_pc;
    r.halted        = model_stop;
    return r;
  endfunction

  // Instruction word with the given opcode and operand line.
  function automatic logic [31:0] instr_word(ssem_pkg::opcode_e op, logic [4:0] line);
    logic [31:0] w;
    w = '0;
    w[ssem_pkg::OpcodeLsb +: ssem_pkg::OpcodeW] = op;
    w[ssem_pkg::LineW-1:0] = line;
    return w;
  endfunction

  // Random instruction word; the stop opcode is made rarer so programs run on.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    w = $urandom();
    if (w[ssem_pkg::OpcodeLsb +: ssem_pkg::OpcodeW] == ssem_pkg::OpStp &&
        $urandom_range(0, 3) != 0) begin
      w[ssem_pkg::OpcodeLsb +: ssem_pkg::OpcodeW] = 3'($urandom_range(0, 6));
    end
    return w;
  endfunction

  // Queue one transaction with a gap drawn from the current idle mode.
  task automatic push_item(ssem_pkg::func_e f, logic [4:0] a, logic [31:0] d);
    pending_t p;
    if ($urandom_range(0, 39) == 0) gap_calm = !gap_calm;
    p.func = f;
    p.addr = a;
    p.data = d;
    p.gap  = gap_calm ? 0 : $urandom_range(0, 11);
    pending_items.insert(pending_items.size(), p);
  endtask

  // One line per mismatch, counted for the final verdict.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: account for the accepted transaction, then present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    bit       nxt_valid;
    pending_t p;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
            machine_apply(ssem_pkg::func_e'(func_q), addr_q, data_q));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_items.size() > 0) begin
        if (pending_items[0].gap > 0) begin
          pending_items[0].gap--;
        end else begin
          p = pending_items.pop_front();
          func_q <= p.func;
          addr_q <= p.addr;
          data_q <= p.data;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: check each accepted result, then draw the stall before the next.
  always @(posedge clk_i or negedge rst_ni) begin
    ssem_pkg::result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", read_word, '0);
        end else begin
          want = expected_results.pop_front();
          if (read_word !== want.read_word)
            report_mismatch("read_word", read_word, want.read_word);
          if (acc_value !== want.acc_value)
            report_mismatch("acc_value", acc_value, want.acc_value);
          if (counter_value !== want.counter_value)
            report_mismatch("counter_value", 32'(counter_value), 32'(want.counter_value));
          if (halted !== want.halted)
            report_mismatch("halted", 32'(halted), 32'(want.halted));
          if (executed !== want.executed)
            report_mismatch("executed", 32'(executed), 32'(want.executed));
        end
        if ($urandom_range(0, 39) == 0) stall_calm = !stall_calm;
        stall_left = stall_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ssem_processor_step_core verification failed");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin
    int unsigned n;
    int unsigned steps;
    machine_clear();

    // Directed program: load, compare with skip, subtract, store, relative
    // and absolute jumps, the second subtract code and a halt.
    push_item(ssem_pkg::FuncRead,  5'd0,  '0);
    push_item(ssem_pkg::FuncRead,  5'd31, '0);
    push_item(ssem_pkg::FuncWrite, 5'd1,  instr_word(ssem_pkg::OpLdn, 5'd31));
    push_item(ssem_pkg::FuncWrite, 5'd31, 32'h8000_0000);
    push_item(ssem_pkg::FuncWrite, 5'd2,  instr_word(ssem_pkg::OpCmp, 5'd0));
    push_item(ssem_pkg::FuncWrite, 5'd4,  instr_word(ssem_pkg::OpSub, 5'd30));
    push_item(ssem_pkg::FuncWrite, 5'd30, 32'h7FFF_FFFF);
    push_item(ssem_pkg::FuncWrite, 5'd5,  instr_word(ssem_pkg::OpSto, 5'd29));
    push_item(ssem_pkg::FuncWrite, 5'd6,  instr_word(ssem_pkg::OpJrp, 5'd28));
    push_item(ssem_pkg::FuncWrite, 5'd28, 32'h0000_0001);
    push_item(ssem_pkg::FuncWrite, 5'd8,  instr_word(ssem_pkg::OpJmp, 5'd27));
    // Only the low bits of this jump target reach the counter.
    push_item(ssem_pkg::FuncWrite, 5'd27, 32'hFFFF_FFE9);
    push_item(ssem_pkg::FuncWrite, 5'd10, instr_word(ssem_pkg::OpSubB, 5'd29));
    push_item(ssem_pkg::FuncWrite, 5'd11, 32'hFFFF_FFFF);
    repeat (8) push_item(ssem_pkg::FuncStep, 5'd0, '0);
    // Halted: steps do nothing, store access still works.
    push_item(ssem_pkg::FuncStep,  5'd0,  '0);
    push_item(ssem_pkg::FuncWrite, 5'd0,  32'h0000_0000);
    push_item(ssem_pkg::FuncRead,  5'd29, '0);
    push_item(ssem_pkg::FuncStep,  5'd31, 32'hFFFF_FFFF);
    // Clear un-halts; a compare on a non-negative accumulator leaves no skip.
    push_item(ssem_pkg::FuncClear, 5'd0,  '0);
    push_item(ssem_pkg::FuncRead,  5'd31, '0);
    push_item(ssem_pkg::FuncWrite, 5'd1,  instr_word(ssem_pkg::OpCmp, 5'd0));
    push_item(ssem_pkg::FuncStep,  5'd0,  '0);
    push_item(ssem_pkg::FuncStep,  5'd0,  '0);

    // Random part: mostly programs followed by runs of steps, some noise.
    while (pending_items.size() < ItemTarget) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1) == 0)
          push_item(ssem_pkg::FuncClear, 5'($urandom()), $urandom());
        if ($urandom_range(0, 5) == 0) begin
          for (int i = 0; i < ssem_pkg::StoreLines; i++)
            push_item(ssem_pkg::FuncWrite, 5'(i), random_instr());
        end else begin
          n = $urandom_range(3, 12);
          repeat (n) push_item(ssem_pkg::FuncWrite, 5'($urandom()), random_instr());
        end
        steps = $urandom_range(4, 30);
        repeat (steps) begin
          case ($urandom_range(0, 9))
            0:       push_item(ssem_pkg::FuncRead,  5'($urandom()), $urandom());
            1:       push_item(ssem_pkg::FuncWrite, 5'($urandom()), random_instr());
            default: push_item(ssem_pkg::FuncStep,  5'($urandom()), $urandom());
          endcase
        end
      end else begin
        n = $urandom_range(5, 15);
        repeat (n)
          push_item(ssem_pkg::func_e'($urandom_range(0, 3)), 5'($urandom()), $urandom());
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results missing", 32'(expected_results.size()), '0);
    if (error_count == 0) begin
      $display("ssem_processor_step_core verification clean");
    end else begin
      $display("ssem_processor_step_core verification failed");
    end
    $finish;
  end

endmodule
